// File: src/i2c_master_transfer_sequencer_unit_macros.svh
// Assertion macros for the I2C master transfer sequencer checker.
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_UNIT_MACROS_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define I2CMTS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define I2CMTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/i2cmts_pkg.sv
// ----------------------------------------------------------------------------
// I2C master transfer sequencer package
// Word types, action and op codes shared by the sequencer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package i2cmts_pkg;

  // Input op codes
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_EVENT = 2'd1;
  localparam logic [1:0] OP_ERROR = 2'd2;

  // Result action codes
  localparam logic [2:0] ACT_WRITE_DR  = 3'd0;
  localparam logic [2:0] ACT_START     = 3'd1;
  localparam logic [2:0] ACT_STOP      = 3'd2;
  localparam logic [2:0] ACT_ACK_ON    = 3'd3;
  localparam logic [2:0] ACT_NACK_STOP = 3'd4;
  localparam logic [2:0] ACT_RX_BYTE   = 3'd5;
  localparam logic [2:0] ACT_CLEAR     = 3'd6;

  // Most result words one input word can cause
  localparam int unsigned MAX_RES = 5;

  typedef struct packed {
    logic [1:0] op;
    logic [6:0] dev_addr;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic [1:0] write_count;
    logic [7:0] read_count;
    logic       start_flag;
    logic       addr_flag;
    logic       rx_flag;
    logic       tx_empty_flag;
    logic       byte_done_flag;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] out_value;
    logic       busy_res;
    logic       last;
  } out_item_t;

  // Transfer state kept between input words
  typedef struct packed {
    logic [6:0]      slave_address;
    logic [1:0]      writes_left;
    logic [7:0]      reads_left;
    logic            write_position;
    logic [1:0][7:0] write_bytes;
    logic            transfer_busy;
  } seq_state_t;

  // Results of one input word, packed from slot 0
  typedef struct packed {
    out_item_t [MAX_RES-1:0] items;
    logic [2:0]              count;
  } res_list_t;

endpackage

// File: src/i2cmts_if.sv
// ----------------------------------------------------------------------------
// I2C master transfer sequencer channels
// Valid/ready channel interfaces for input words and result words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface i2cmts_in_if;
  logic                 valid;
  logic                 ready;
  i2cmts_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface i2cmts_out_if;
  logic                  valid;
  logic                  ready;
  i2cmts_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: src/i2cmts_eval.sv
// ----------------------------------------------------------------------------
// I2C master transfer sequencer evaluation
// Works one registered input word against the transfer state: produces the
// packed list of result words and the next transfer state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2cmts_eval (
  input  i2cmts_pkg::in_item_t   item_i,
  input  i2cmts_pkg::seq_state_t st_i,
  output i2cmts_pkg::seq_state_t st_o,
  output i2cmts_pkg::res_list_t  res_o
);
  import i2cmts_pkg::*;

  function automatic out_item_t mk(input logic [2:0] act, input logic [7:0] val,
                                   input logic busy);
    out_item_t w;
    w.action    = act;
    w.out_value = val;
    w.busy_res  = busy;
    w.last      = 1'b0;
    return w;
  endfunction

  // Flag branches in fixed order: start sent, address sent, receive, transmit
  always_comb begin
    seq_state_t s;
    res_list_t  r;
    logic [2:0] n;
    s = st_i;
    r = '0;
    n = 3'd0;
    unique case (item_i.op)
      OP_START: begin
        s.slave_address  = item_i.dev_addr;
        s.write_bytes[0] = item_i.first_byte;
        s.write_bytes[1] = item_i.second_byte;
        s.writes_left    = (item_i.write_count == 2'd3) ? 2'd2 : item_i.write_count;
        s.reads_left     = item_i.read_count;
        s.write_position = 1'b0;
        s.transfer_busy  = 1'b1;
        r.items[n] = mk(ACT_START, 8'd0, 1'b1);
        n = n + 3'd1;
      end
      OP_EVENT: begin
        // address byte, read direction when no writes remain
        if (item_i.start_flag) begin
          r.items[n] = mk(ACT_WRITE_DR, {s.slave_address, s.writes_left == 2'd0},
                          s.transfer_busy);
          n = n + 3'd1;
        end
        if (item_i.addr_flag) begin
          if (s.writes_left != 2'd0) begin
            r.items[n] = mk(ACT_WRITE_DR, s.write_bytes[s.write_position],
                            s.transfer_busy);
            s.write_position = ~s.write_position;
            s.writes_left    = s.writes_left - 2'd1;
          end else if (s.reads_left > 8'd1) begin
            r.items[n] = mk(ACT_ACK_ON, 8'd0, s.transfer_busy);
          end else begin
            r.items[n] = mk(ACT_STOP, 8'd0, s.transfer_busy);
          end
          n = n + 3'd1;
        end
        // received byte; count stays at zero once exhausted
        if (item_i.rx_flag) begin
          if (s.reads_left != 8'd0) s.reads_left = s.reads_left - 8'd1;
          if (s.reads_left == 8'd0) s.transfer_busy = 1'b0;
          r.items[n] = mk(ACT_RX_BYTE, item_i.rx_byte, s.transfer_busy);
          n = n + 3'd1;
          if (s.reads_left == 8'd1) begin
            r.items[n] = mk(ACT_NACK_STOP, 8'd0, s.transfer_busy);
            n = n + 3'd1;
          end
        end
        // transmit empty, blocked while a byte is still finishing
        if (item_i.tx_empty_flag && !item_i.byte_done_flag) begin
          if (s.writes_left != 2'd0) begin
            r.items[n] = mk(ACT_WRITE_DR, s.write_bytes[s.write_position],
                            s.transfer_busy);
            s.write_position = ~s.write_position;
            s.writes_left    = s.writes_left - 2'd1;
          end else if (s.reads_left != 8'd0) begin
            r.items[n] = mk(ACT_START, 8'd0, s.transfer_busy);
          end else begin
            s.transfer_busy = 1'b0;
            r.items[n] = mk(ACT_STOP, 8'd0, 1'b0);
          end
          n = n + 3'd1;
        end
      end
      OP_ERROR: begin
        r.items[n] = mk(ACT_CLEAR, 8'd0, s.transfer_busy);
        n = n + 3'd1;
        s.transfer_busy = 1'b0;
        r.items[n] = mk(ACT_STOP, 8'd0, 1'b0);
        n = n + 3'd1;
      end
      default: ;
    endcase
    r.count = n;
    st_o  = s;
    res_o = r;
  end

endmodule

// File: src/i2cmts_outbuf.sv
// ----------------------------------------------------------------------------
// I2C master transfer sequencer result buffer
// Holds the result list of one input word and hands it out one word per
// cycle while the output is ready; flags the last word of the list.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2cmts_outbuf (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load_i,
  input  i2cmts_pkg::res_list_t list_i,
  output logic                  can_load_o,
  i2cmts_out_if.source          out_ch
);
  import i2cmts_pkg::*;

  out_item_t [MAX_RES-1:0] items_r;
  logic [2:0]              cnt_r, cnt_nxt;
  logic [2:0]              idx_r, idx_nxt;
  logic                    is_last;
  logic                    empty;

  assign empty   = (idx_r == cnt_r);
  assign is_last = (idx_r == (cnt_r - 3'd1));

  // Output word: stored entry with last marked
  always_comb begin
    out_ch.valid          = !empty;
    out_ch.data           = items_r[idx_r];
    out_ch.data.last      = is_last;
  end

  assign can_load_o = empty || (out_ch.ready && is_last);

  // Index and count update
  always_comb begin
    idx_nxt = idx_r;
    cnt_nxt = cnt_r;
    if (load_i) begin
      idx_nxt = 3'd0;
      cnt_nxt = list_i.count;
    end else if (!empty && out_ch.ready) begin
      idx_nxt = idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 3'd0;
      cnt_r <= 3'd0;
    end else begin
      idx_r <= idx_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk) begin
    if (load_i) items_r <= list_i.items;
  end

endmodule

// File: src/i2c_master_transfer_sequencer_unit.sv
// ----------------------------------------------------------------------------
// I2C master transfer sequencer
// Steps an I2C master transfer (up to two written bytes, then up to 255 read
// bytes) from peripheral event words and emits peripheral actions.
// ----------------------------------------------------------------------------
//  Channel  Dir  Word                         Accepted when
//  in_ch    in   op, address, bytes, flags    in_ch.valid && in_ch.ready
//  out_ch   out  action, value, busy, last    out_ch.valid && out_ch.ready
//
// An input word is registered, then evaluated combinationally into 0..5 result
// words that are loaded into the result buffer; the buffer drains one word per
// cycle while out_ch.ready is high. The input register refills while the
// buffer drains.
// Synchronous active-low reset clears the transfer state and both stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2c_master_transfer_sequencer_unit (
  input logic          clk,
  input logic          rst_n,
  i2cmts_in_if.sink    in_ch,
  i2cmts_out_if.source out_ch
);
  import i2cmts_pkg::*;

  in_item_t   in_r;
  logic       in_vld_r, in_vld_nxt;
  seq_state_t st_r, st_nxt;
  res_list_t  res;
  logic       can_load;
  logic       take;

  // Input stage hands its word on when the buffer can take a list
  assign take        = in_vld_r && can_load;
  assign in_ch.ready = !in_vld_r || take;
  assign in_vld_nxt  = in_ch.valid ? 1'b1 : (in_vld_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      st_r     <= '0;
    end else begin
      in_vld_r <= in_ch.ready ? in_vld_nxt : in_vld_r;
      if (take) st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) in_r <= in_ch.data;
  end

  i2cmts_eval u_eval (
    .item_i (in_r),
    .st_i   (st_r),
    .st_o   (st_nxt),
    .res_o  (res)
  );

  i2cmts_outbuf u_outbuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_i     (take),
    .list_i     (res),
    .can_load_o (can_load),
    .out_ch     (out_ch)
  );

endmodule

// File: src/i2cmts_checker.sv
// ----------------------------------------------------------------------------
// I2C master transfer sequencer checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "i2c_master_transfer_sequencer_unit_macros.svh"

module i2cmts_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_ready,
  input i2cmts_pkg::out_item_t out_data
);
  import i2cmts_pkg::*;

  // stalled result word holds
  `I2CMTS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result word changed while stalled")

  // only data-register writes and received bytes carry a value
  `I2CMTS_ASSERT_NOW(a_zero_value, clk, rst_n, out_valid && out_data.action != ACT_WRITE_DR && out_data.action != ACT_RX_BYTE, out_data.out_value == 8'd0, "nonzero value on control action")

  // clear status is always followed at once by the final idle stop
  `I2CMTS_ASSERT_NEXT(a_clear_stop, clk, rst_n, out_valid && out_ready && out_data.action == ACT_CLEAR, out_valid && out_data.action == ACT_STOP && !out_data.busy_res && out_data.last, "clear status not followed by stop")

  // clear status is never the final word of an input word
  `I2CMTS_ASSERT_NOW(a_clear_not_last, clk, rst_n, out_valid && out_data.action == ACT_CLEAR, !out_data.last, "clear status marked as last word")

endmodule

bind i2c_master_transfer_sequencer_unit i2cmts_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);
